@@ design/ave_pkg.sv @@
// Shared types, step addresses and helpers for the attribute value byte encoder.
package ave_pkg;

    localparam int UPC_W = 3;

    localparam logic [1:0] MODE_SINT = 2'd0;
    localparam logic [1:0] MODE_UINT = 2'd1;
    localparam logic [1:0] MODE_STR  = 2'd2;
    localparam logic [1:0] MODE_RAW  = 2'd3;

    localparam logic [1:0] WCODE_1B = 2'd0;
    localparam logic [1:0] WCODE_2B = 2'd1;
    localparam logic [1:0] WCODE_4B = 2'd2;
    localparam logic [1:0] WCODE_8B = 2'd3;

    localparam logic [UPC_W-1:0] STEP_IDLE     = 3'd0;
    localparam logic [UPC_W-1:0] STEP_INT      = 3'd1;
    localparam logic [UPC_W-1:0] STEP_LEB_STR  = 3'd2;
    localparam logic [UPC_W-1:0] STEP_LEB_SIZE = 3'd3;
    localparam logic [UPC_W-1:0] STEP_LEB_OFF  = 3'd4;

    localparam logic [63:0] MAX_1B  = 64'h0000_0000_0000_00ff;
    localparam logic [63:0] MAX_2B  = 64'h0000_0000_0000_ffff;
    localparam logic [63:0] MAX_4B  = 64'h0000_0000_ffff_ffff;
    localparam logic [6:0]  LEB_LOW = 7'h7f;

    // Control word: one per microprogram step.
    typedef struct packed {
        logic             wait_in;      // step takes a new request
        logic             src_leb;      // emit LEB128 group, else integer byte
        logic             last_on_done; // mark final byte when the loop ends
        logic             load_off;     // swap in the heap offset when the loop ends
        logic [UPC_W-1:0] jump;         // next step when the loop ends
    } ucw_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic src_leb;
        logic load_off;
    } dp_ctrl_t;

    typedef struct packed {
        logic       done;
        logic [7:0] data;
        logic [1:0] wcode;
    } dp_stat_t;

    function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] mode);
        logic [UPC_W-1:0] step;
        case (mode)
            MODE_SINT: step = STEP_INT;
            MODE_UINT: step = STEP_INT;
            MODE_STR:  step = STEP_LEB_STR;
            MODE_RAW:  step = STEP_LEB_SIZE;
            default:   step = STEP_IDLE;
        endcase
        return step;
    endfunction

    function automatic logic [1:0] width_of(input logic [63:0] mag);
        logic [1:0] w;
        if (mag <= MAX_1B) begin
            w = WCODE_1B;
        end else if (mag <= MAX_2B) begin
            w = WCODE_2B;
        end else if (mag <= MAX_4B) begin
            w = WCODE_4B;
        end else begin
            w = WCODE_8B;
        end
        return w;
    endfunction

endpackage

@@ design/ave_ucode_rom.sv @@
// Control store: the microprogram, one control word per step.
module ave_ucode_rom import ave_pkg::*; (
    input  logic [UPC_W-1:0] upc,
    output ucw_t             ucw
);

    always_comb begin
        case (upc)
            STEP_IDLE:     ucw = '{wait_in: 1'b1, src_leb: 1'b0, last_on_done: 1'b0,
                                   load_off: 1'b0, jump: STEP_IDLE};
            STEP_INT:      ucw = '{wait_in: 1'b0, src_leb: 1'b0, last_on_done: 1'b1,
                                   load_off: 1'b0, jump: STEP_IDLE};
            STEP_LEB_STR:  ucw = '{wait_in: 1'b0, src_leb: 1'b1, last_on_done: 1'b1,
                                   load_off: 1'b0, jump: STEP_IDLE};
            STEP_LEB_SIZE: ucw = '{wait_in: 1'b0, src_leb: 1'b1, last_on_done: 1'b0,
                                   load_off: 1'b1, jump: STEP_LEB_OFF};
            STEP_LEB_OFF:  ucw = '{wait_in: 1'b0, src_leb: 1'b1, last_on_done: 1'b1,
                                   load_off: 1'b0, jump: STEP_IDLE};
            default:       ucw = '{wait_in: 1'b1, src_leb: 1'b0, last_on_done: 1'b0,
                                   load_off: 1'b0, jump: STEP_IDLE};
        endcase
    end

endmodule

@@ design/ave_datapath.sv @@
// Datapath: value shifter, heap offset holder, byte counter and width select.
module ave_datapath import ave_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_ctrl_t    ctrl,
    input  logic [1:0]  mode,
    input  logic [63:0] value_in,
    input  logic [63:0] heap_offset,
    output dp_stat_t    stat
);

    logic [63:0] data_reg, data_next;
    logic [63:0] off_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  wcode_reg, wcode_next;

    logic [63:0] mag;
    logic [1:0]  wsel;
    logic [63:0] int_aligned;
    logic [2:0]  int_cnt;
    logic [56:0] leb_rest;
    logic        is_int;

    assign is_int   = (mode == MODE_SINT) || (mode == MODE_UINT);
    assign leb_rest = data_reg[63:7];

    always_comb begin
        if (mode == MODE_UINT) begin
            mag = value_in;
        end else if (!value_in[63]) begin
            mag = {value_in[62:0], 1'b0};
        end else begin
            mag = {~value_in[62:0], 1'b0};
        end
        wsel = width_of(mag);
        case (wsel)
            WCODE_1B: begin
                int_aligned = {value_in[7:0], 56'd0};
                int_cnt     = 3'd0;
            end
            WCODE_2B: begin
                int_aligned = {value_in[15:0], 48'd0};
                int_cnt     = 3'd1;
            end
            WCODE_4B: begin
                int_aligned = {value_in[31:0], 32'd0};
                int_cnt     = 3'd3;
            end
            default: begin
                int_aligned = value_in;
                int_cnt     = 3'd7;
            end
        endcase
    end

    always_comb begin
        stat.done  = ctrl.src_leb ? (leb_rest == 57'd0) : (cnt_reg == 3'd0);
        stat.data  = ctrl.src_leb ? {(leb_rest != 57'd0), data_reg[6:0] & LEB_LOW}
                                  : data_reg[63:56];
        stat.wcode = wcode_reg;
    end

    always_comb begin
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        wcode_next = wcode_reg;
        if (ctrl.load) begin
            data_next  = is_int ? int_aligned : value_in;
            cnt_next   = is_int ? int_cnt : 3'd0;
            wcode_next = is_int ? wsel : WCODE_1B;
        end else if (ctrl.advance) begin
            if (ctrl.src_leb) begin
                if (stat.done && ctrl.load_off) begin
                    data_next = off_reg;
                end else begin
                    data_next = {7'd0, leb_rest};
                end
            end else begin
                data_next = {data_reg[55:0], 8'd0};
                cnt_next  = cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 3'd0;
            wcode_reg <= WCODE_1B;
        end else begin
            cnt_reg   <= cnt_next;
            wcode_reg <= wcode_next;
        end
        data_reg <= data_next;
        if (ctrl.load) begin
            off_reg <= heap_offset;
        end
    end

endmodule

@@ design/attribute_value_byte_encoder.sv @@
// Top level: microprogram sequencer, result register and datapath hookup.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  request | s_valid s_ready s_mode s_value_in          | in
//          | s_heap_offset                              |
//  result  | m_valid m_ready m_out_byte m_last          | out
//          | m_width_code                               |
//
// A request is loaded in the idle step; the microprogram steps then issue its
// N bytes, N = 1..20.
// The single result register sets the pace: a step only issues a byte when that
// register is empty or being taken. A stalled result stalls the step counter.
// Synchronous active-low reset returns the step counter to idle and empties
// the result register.
module attribute_value_byte_encoder import ave_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [63:0] s_value_in,
    input  logic [63:0] s_heap_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic [1:0]  m_width_code
);

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg;
    logic             m_last_reg;
    logic [1:0]       m_wcode_reg;

    ucw_t     ucw;
    dp_ctrl_t dp_ctrl;
    dp_stat_t dp_stat;
    logic     accept;
    logic     out_free;
    logic     emit;

    ave_ucode_rom u_rom (
        .upc (upc_reg),
        .ucw (ucw)
    );

    ave_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (dp_ctrl),
        .mode        (s_mode),
        .value_in    (s_value_in),
        .heap_offset (s_heap_offset),
        .stat        (dp_stat)
    );

    assign s_ready  = ucw.wait_in;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = !ucw.wait_in && out_free;

    assign dp_ctrl.load     = accept;
    assign dp_ctrl.advance  = emit;
    assign dp_ctrl.src_leb  = ucw.src_leb;
    assign dp_ctrl.load_off = ucw.load_off;

    always_comb begin
        upc_next     = upc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            upc_next = dispatch(s_mode);
        end else if (emit) begin
            m_valid_next = 1'b1;
            if (dp_stat.done) begin
                upc_next = ucw.jump;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= STEP_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            m_valid_reg <= m_valid_next;
        end
        if (emit) begin
            m_byte_reg  <= dp_stat.data;
            m_last_reg  <= dp_stat.done && ucw.last_on_done;
            m_wcode_reg <= dp_stat.wcode;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_last       = m_last_reg;
    assign m_width_code = m_wcode_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("sequencer still idle after a request was taken");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && dp_stat.done && ucw.last_on_done) |=> s_ready && m_valid && m_last)
        else $error("final byte issued without returning to idle");

    a_leb_width_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && ucw.src_leb) |-> (dp_stat.wcode == WCODE_1B))
        else $error("LEB128 byte carries a nonzero width code");

    a_no_last_midway: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !(dp_stat.done && ucw.last_on_done)) |=> !s_ready)
        else $error("sequencer went idle before the final byte");

endmodule

@@ tb/tb_attribute_value_byte_encoder.sv @@
// Testbench for the attribute value byte encoder: directed table plus random requests.
module tb_attribute_value_byte_encoder;
    import ave_pkg::*;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode        = MODE_SINT;
    logic [63:0] s_value_in    = '0;
    logic [63:0] s_heap_offset = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic [1:0]  m_width_code;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] wcode;
    } enc_byte_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] value;
        logic [63:0] offset;
        logic [4:0]  n_typed;
        logic [79:0] typed_seq;
        logic [1:0]  typed_wcode;
    } stim_row_t;

    enc_byte_t expected_bytes[$];
    stim_row_t dir_rows[$];
    int        err_count         = 0;
    int        sent_count        = 0;
    int        sender_idle_pct   = 35;
    int        receiver_idle_pct = 62;
    bit        hold_done         = 1'b0;

    attribute_value_byte_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_value_in    (s_value_in),
        .s_heap_offset (s_heap_offset),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_width_code  (m_width_code)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        if (err_count <= 100) begin
            $display("mismatch on %s at %0t: got %02h, want %02h", what, $time, got, want);
        end
    endtask

    function automatic stim_row_t row(input logic [1:0] mode, input logic [63:0] value,
                                      input logic [63:0] offset, input logic [4:0] n_typed,
                                      input logic [79:0] typed_seq, input logic [1:0] wcode);
        stim_row_t r;
        r.mode        = mode;
        r.value       = value;
        r.offset      = offset;
        r.n_typed     = n_typed;
        r.typed_seq   = typed_seq;
        r.typed_wcode = wcode;
        return r;
    endfunction

    function automatic logic [63:0] shaped_value();
        logic [63:0] v;
        int          nbits;
        v     = {$urandom, $urandom};
        nbits = $urandom_range(0, 64);
        if (nbits < 64) begin
            v = v & ((64'd1 << nbits) - 64'd1);
        end
        if ($urandom_range(0, 3) == 0) begin
            v = ~v;
        end
        return v;
    endfunction

    function automatic void predict_encoding(input logic [1:0] mode, input logic [63:0] val,
                                             input logic [63:0] off);
        logic [7:0]  seq[$];
        logic [63:0] mag;
        logic [63:0] v;
        logic [1:0]  wc;
        enc_byte_t   e;
        int          nb;
        int          parts;
        wc = WCODE_1B;
        if (mode == MODE_SINT || mode == MODE_UINT) begin
            if (mode == MODE_UINT) begin
                mag = val;
            end else if (val[63] == 1'b0) begin
                mag = val << 1;
            end else begin
                mag = (~val) << 1;
            end
            if (mag[63:8] == '0) begin
                wc = WCODE_1B;
            end else if (mag[63:16] == '0) begin
                wc = WCODE_2B;
            end else if (mag[63:32] == '0) begin
                wc = WCODE_4B;
            end else begin
                wc = WCODE_8B;
            end
            nb = 1 << wc;
            for (int i = nb - 1; i >= 0; i--) begin
                seq.push_back(val[8*i +: 8]);
            end
        end else begin
            parts = (mode == MODE_RAW) ? 2 : 1;
            for (int p = 0; p < parts; p++) begin
                v = (p == 0) ? val : off;
                do begin
                    seq.push_back({v[63:7] != '0, v[6:0]});
                    v = v >> 7;
                end while (v != '0);
            end
        end
        for (int k = 0; k < seq.size(); k++) begin
            e.data  = seq[k];
            e.last  = (k == seq.size() - 1);
            e.wcode = wc;
            expected_bytes.push_back(e);
        end
    endfunction

    task automatic send_request(input stim_row_t r);
        enc_byte_t e;
        int        nt;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= r.mode;
        s_value_in    <= r.value;
        s_heap_offset <= r.offset;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        nt = int'(r.n_typed);
        if (nt == 0) begin
            predict_encoding(r.mode, r.value, r.offset);
        end else begin
            for (int k = 0; k < nt; k++) begin
                e.data  = r.typed_seq[8*(nt-1-k) +: 8];
                e.last  = (k == nt - 1);
                e.wcode = r.typed_wcode;
                expected_bytes.push_back(e);
            end
        end
        sent_count++;
        if (sent_count == 82) begin
            sender_idle_pct   = 62;
            receiver_idle_pct = 35;
        end else if (sent_count == 163) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
    endtask

    always @(posedge aclk) begin : check_results
        enc_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unrequested byte", m_out_byte, 8'h00);
            end else begin
                want = expected_bytes.pop_front();
                if (m_out_byte !== want.data) begin
                    report_mismatch("out_byte", m_out_byte, want.data);
                end
                if (m_last !== want.last) begin
                    report_mismatch("last", {7'd0, m_last}, {7'd0, want.last});
                end
                if (m_width_code !== want.wcode) begin
                    report_mismatch("width_code", {6'd0, m_width_code}, {6'd0, want.wcode});
                end
            end
        end
    end

    initial begin
        @(posedge aresetn);
        forever begin
            if (!hold_done && sent_count >= 163) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            @(posedge aclk);
        end
    end

    initial begin
        #4000000;
        $display("tb_attribute_value_byte_encoder: errors");
        $finish;
    end

    initial begin
        stim_row_t r;
        dir_rows.push_back(row(MODE_UINT, 64'h0, 64'h0, 5'd1, 80'h00, WCODE_1B));
        dir_rows.push_back(row(MODE_UINT, 64'hff, 64'h0, 5'd1, 80'hff, WCODE_1B));
        dir_rows.push_back(row(MODE_UINT, 64'h100, 64'h0, 5'd2, 80'h0100, WCODE_2B));
        dir_rows.push_back(row(MODE_UINT, 64'hffff, 64'h0, 5'd2, 80'hffff, WCODE_2B));
        dir_rows.push_back(row(MODE_UINT, 64'h1_0000, 64'h0, 5'd4, 80'h0001_0000, WCODE_4B));
        dir_rows.push_back(row(MODE_UINT, 64'hffff_ffff, 64'h0, 5'd4, 80'hffff_ffff,
                               WCODE_4B));
        dir_rows.push_back(row(MODE_UINT, 64'h1_0000_0000, 64'h0, 5'd8,
                               80'h0000_0001_0000_0000, WCODE_8B));
        dir_rows.push_back(row(MODE_UINT, '1, 64'h0, 5'd8, 80'hffff_ffff_ffff_ffff,
                               WCODE_8B));
        dir_rows.push_back(row(MODE_SINT, 64'h0, 64'h0, 5'd1, 80'h00, WCODE_1B));
        dir_rows.push_back(row(MODE_SINT, '1, 64'h0, 5'd1, 80'hff, WCODE_1B));
        dir_rows.push_back(row(MODE_SINT, 64'h7f, 64'h0, 5'd1, 80'h7f, WCODE_1B));
        dir_rows.push_back(row(MODE_SINT, 64'h80, 64'h0, 5'd2, 80'h0080, WCODE_2B));
        dir_rows.push_back(row(MODE_SINT, 64'hffff_ffff_ffff_ff80, 64'h0, 5'd1, 80'h80,
                               WCODE_1B));
        dir_rows.push_back(row(MODE_SINT, 64'hffff_ffff_ffff_ff7f, 64'h0, 5'd2, 80'hff7f,
                               WCODE_2B));
        dir_rows.push_back(row(MODE_SINT, 64'h7fff_ffff_ffff_ffff, 64'h0, 5'd8,
                               80'h7fff_ffff_ffff_ffff, WCODE_8B));
        dir_rows.push_back(row(MODE_SINT, 64'h8000_0000_0000_0000, 64'h0, 5'd8,
                               80'h8000_0000_0000_0000, WCODE_8B));
        dir_rows.push_back(row(MODE_STR, 64'h0, 64'h0, 5'd1, 80'h00, WCODE_1B));
        dir_rows.push_back(row(MODE_STR, 64'h7f, 64'h0, 5'd1, 80'h7f, WCODE_1B));
        dir_rows.push_back(row(MODE_STR, 64'h80, 64'h0, 5'd2, 80'h8001, WCODE_1B));
        dir_rows.push_back(row(MODE_STR, '1, 64'h0, 5'd10, 80'hffff_ffff_ffff_ffff_ff01,
                               WCODE_1B));
        dir_rows.push_back(row(MODE_RAW, 64'h0, 64'h0, 5'd2, 80'h0000, WCODE_1B));
        dir_rows.push_back(row(MODE_RAW, '1, '1, 5'd0, '0, WCODE_1B));
        dir_rows.push_back(row(MODE_UINT, 64'h5, '1, 5'd0, '0, WCODE_1B));
        dir_rows.push_back(row(MODE_SINT, 64'hffff_ffff_ffff_fffe, 64'ha5a5_a5a5_a5a5_a5a5,
                               5'd0, '0, WCODE_1B));
        dir_rows.push_back(row(MODE_STR, 64'd300, '1, 5'd0, '0, WCODE_1B));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dir_rows[i]) begin
            send_request(dir_rows[i]);
        end
        repeat (195) begin
            r = row(2'($urandom_range(0, 3)), shaped_value(), shaped_value(), 5'd0, '0,
                    WCODE_1B);
            send_request(r);
        end
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (err_count == 0 && expected_bytes.size() == 0) begin
            $display("tb_attribute_value_byte_encoder: clean");
        end else begin
            $display("tb_attribute_value_byte_encoder: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/ave_pkg.sv
design/ave_ucode_rom.sv
design/ave_datapath.sv
design/attribute_value_byte_encoder.sv
tb/tb_attribute_value_byte_encoder.sv
